FILE: design/caaf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// caaf_pkg
// Shared types and codes for the accumulator ALU: operation codes, compare
// register codes, status bit positions and the item and register structs.
// ----------------------------------------------------------------------------
package caaf_pkg;

   typedef enum logic [3:0] {
      ACT_LDA = 4'd0,
      ACT_LDX = 4'd1,
      ACT_LDY = 4'd2,
      ACT_AND = 4'd3,
      ACT_ORA = 4'd4,
      ACT_EOR = 4'd5,
      ACT_ADC = 4'd6,
      ACT_SBC = 4'd7,
      ACT_CMP = 4'd8,
      ACT_ASL = 4'd9,
      ACT_LSR = 4'd10,
      ACT_ROL = 4'd11,
      ACT_ROR = 4'd12,
      ACT_INC = 4'd13,
      ACT_DEC = 4'd14
   } action_type;

   localparam logic [1:0] SEL_ACC = 2'd0;
   localparam logic [1:0] SEL_X   = 2'd1;
   localparam logic [1:0] SEL_Y   = 2'd2;

   localparam int FLAG_N_BIT = 7;
   localparam int FLAG_V_BIT = 6;
   localparam int FLAG_Z_BIT = 1;
   localparam int FLAG_C_BIT = 0;

   localparam logic [15:0] MASK_WIDE   = 16'hffff;
   localparam logic [15:0] MASK_NARROW = 16'h00ff;
   localparam logic [15:0] SIGN_WIDE   = 16'h8000;
   localparam logic [15:0] SIGN_NARROW = 16'h0080;

   typedef struct packed {
      logic [3:0]  action;
      logic [15:0] operand;
      logic        wide;
      logic [1:0]  compare_select;
      logic        to_memory;
   } req_item_type;

   typedef struct packed {
      logic [15:0] result_value;
      logic [7:0]  flags;
      logic [15:0] acc_out;
      logic [15:0] x_out;
      logic [15:0] y_out;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0] acc;
      logic [15:0] x;
      logic [15:0] y;
      logic        flag_n;
      logic        flag_v;
      logic        flag_z;
      logic        flag_c;
   } cpu_state_type;

endpackage
`default_nettype wire

FILE: design/caaf_channels.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// caaf channels
// Valid/ready channels for ALU requests and ALU responses.
// ----------------------------------------------------------------------------
interface caaf_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [15:0] operand;
   logic        wide;
   logic [1:0]  compare_select;
   logic        to_memory;

   modport source (
      output valid, action, operand, wide, compare_select, to_memory,
      input  ready
   );
   modport sink (
      input  valid, action, operand, wide, compare_select, to_memory,
      output ready
   );
endinterface

interface caaf_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result_value;
   logic [7:0]  flags;
   logic [15:0] acc_out;
   logic [15:0] x_out;
   logic [15:0] y_out;

   modport source (
      output valid, result_value, flags, acc_out, x_out, y_out,
      input  ready
   );
   modport sink (
      input  valid, result_value, flags, acc_out, x_out, y_out,
      output ready
   );
endinterface
`default_nettype wire

FILE: design/caaf_alu.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// caaf_alu
// Single-pass ALU: from one request and the current A/X/Y and flags, forms
// the next register state and the response item.
// ----------------------------------------------------------------------------
module caaf_alu (
   input  caaf_pkg::req_item_type  item,
   input  caaf_pkg::cpu_state_type state,
   output caaf_pkg::cpu_state_type state_next,
   output caaf_pkg::rsp_item_type  rsp
);
   import caaf_pkg::*;

   logic [15:0]   mask;
   logic [15:0]   sign_fill;
   logic [15:0]   opd;
   logic [15:0]   acc_m;
   logic [15:0]   cmp_reg;
   logic [15:0]   src;
   logic          src_sign;
   logic          cin;
   logic [16:0]   sum;
   logic [16:0]   diff;
   logic [16:0]   cmp_diff;
   logic [15:0]   z;
   logic          acc_write;
   logic          nz_write;
   cpu_state_type nxt;

   always_comb begin
      mask      = item.wide ? MASK_WIDE : MASK_NARROW;
      sign_fill = item.wide ? SIGN_WIDE : SIGN_NARROW;
      opd       = item.operand & mask;
      acc_m     = state.acc & mask;
      case (item.compare_select)
         SEL_X:   cmp_reg = state.x & mask;
         SEL_Y:   cmp_reg = state.y & mask;
         default: cmp_reg = acc_m;
      endcase
      src      = item.to_memory ? opd : acc_m;
      src_sign = item.wide ? src[15] : src[7];
      cin      = state.flag_c;
      sum      = {1'b0, acc_m} + {1'b0, opd} + {16'd0, cin};
      // borrow is the inverted carry
      diff     = {1'b0, acc_m} - {1'b0, opd} - {16'd0, ~cin};
      cmp_diff = {1'b0, cmp_reg} - {1'b0, opd};

      nxt       = state;
      z         = '0;
      acc_write = 1'b0;
      nz_write  = 1'b0;

      unique case (action_type'(item.action))
         ACT_LDA: begin
            z = opd; acc_write = 1'b1; nz_write = 1'b1;
         end
         ACT_LDX: begin
            z = opd; nxt.x = opd; nz_write = 1'b1;
         end
         ACT_LDY: begin
            z = opd; nxt.y = opd; nz_write = 1'b1;
         end
         ACT_AND: begin
            z = acc_m & opd; acc_write = 1'b1; nz_write = 1'b1;
         end
         ACT_ORA: begin
            z = acc_m | opd; acc_write = 1'b1; nz_write = 1'b1;
         end
         ACT_EOR: begin
            z = acc_m ^ opd; acc_write = 1'b1; nz_write = 1'b1;
         end
         ACT_ADC: begin
            z          = sum[15:0] & mask;
            nxt.flag_c = item.wide ? sum[16] : sum[8];
            nxt.flag_v = ((~(acc_m ^ opd) & (acc_m ^ z) & sign_fill) != 16'd0);
            acc_write  = 1'b1;
            nz_write   = 1'b1;
         end
         ACT_SBC: begin
            z          = diff[15:0] & mask;
            nxt.flag_c = ~diff[16];
            nxt.flag_v = (((acc_m ^ opd) & (acc_m ^ z) & sign_fill) != 16'd0);
            acc_write  = 1'b1;
            nz_write   = 1'b1;
         end
         ACT_CMP: begin
            z          = cmp_diff[15:0] & mask;
            nxt.flag_c = ~cmp_diff[16];
            nz_write   = 1'b1;
         end
         ACT_ASL: begin
            nxt.flag_c = src_sign;
            z          = {src[14:0], 1'b0} & mask;
            acc_write  = ~item.to_memory;
            nz_write   = 1'b1;
         end
         ACT_LSR: begin
            nxt.flag_c = src[0];
            z          = {1'b0, src[15:1]};
            acc_write  = ~item.to_memory;
            nz_write   = 1'b1;
         end
         ACT_ROL: begin
            nxt.flag_c = src_sign;
            z          = {src[14:0], cin} & mask;
            acc_write  = ~item.to_memory;
            nz_write   = 1'b1;
         end
         ACT_ROR: begin
            nxt.flag_c = src[0];
            z          = {1'b0, src[15:1]} | (cin ? sign_fill : 16'd0);
            acc_write  = ~item.to_memory;
            nz_write   = 1'b1;
         end
         ACT_INC: begin
            z         = (src + 16'd1) & mask;
            acc_write = ~item.to_memory;
            nz_write  = 1'b1;
         end
         ACT_DEC: begin
            z         = (src - 16'd1) & mask;
            acc_write = ~item.to_memory;
            nz_write  = 1'b1;
         end
         default: begin
            // unused code: no-op, result reads zero
            z = '0;
         end
      endcase

      // narrow writes keep the high byte of A
      if (acc_write) begin
         nxt.acc = item.wide ? z : {state.acc[15:8], z[7:0]};
      end
      if (nz_write) begin
         nxt.flag_n = item.wide ? z[15] : z[7];
         nxt.flag_z = (z == 16'd0);
      end

      state_next             = nxt;
      rsp.result_value       = z;
      rsp.flags              = '0;
      rsp.flags[FLAG_N_BIT]  = nxt.flag_n;
      rsp.flags[FLAG_V_BIT]  = nxt.flag_v;
      rsp.flags[FLAG_Z_BIT]  = nxt.flag_z;
      rsp.flags[FLAG_C_BIT]  = nxt.flag_c;
      rsp.acc_out            = nxt.acc;
      rsp.x_out              = nxt.x;
      rsp.y_out              = nxt.y;
   end

endmodule
`default_nettype wire

FILE: design/cpu_accumulator_alu_flags.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_accumulator_alu_flags
// 65C816-style 8/16-bit ALU holding A, X, Y and the N/V/Z/C flags.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while the response side is not
// stalled, and returns one response per request. A request lands in the
// input register s1_ff; the ALU pass from that register and the A/X/Y/flag
// registers writes the new register state and the response register s2_ff
// at the same edge, so the next request sees the updated state without a
// bubble. The output register lets a new request in while a finished
// response waits to be taken.
module cpu_accumulator_alu_flags (
   input  logic      clock,
   input  logic      reset,
   caaf_req_if.sink  req_chan,
   caaf_rsp_if.source rsp_chan
);
   import caaf_pkg::*;

   req_item_type  s1_ff;
   req_item_type  s1_in;
   logic          s1_valid_ff;
   logic          s1_valid_in;
   rsp_item_type  s2_ff;
   rsp_item_type  s2_in;
   logic          s2_valid_ff;
   logic          s2_valid_in;
   cpu_state_type state_ff;
   cpu_state_type state_in;
   cpu_state_type alu_state;
   rsp_item_type  alu_rsp;
   logic          advance;
   logic          req_xfer;

   caaf_alu u_alu (
      .item       (s1_ff),
      .state      (state_ff),
      .state_next (alu_state),
      .rsp        (alu_rsp)
   );

   assign advance        = s1_valid_ff && (!s2_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff;
      s2_in       = s2_ff;
      s2_valid_in = s2_valid_ff;
      state_in    = state_ff;
      if (rsp_chan.ready) begin
         s2_valid_in = 1'b0;
      end
      if (advance) begin
         s2_in       = alu_rsp;
         s2_valid_in = 1'b1;
         state_in    = alu_state;
         s1_valid_in = 1'b0;
      end
      if (req_xfer) begin
         s1_in.action         = req_chan.action;
         s1_in.operand        = req_chan.operand;
         s1_in.wide           = req_chan.wide;
         s1_in.compare_select = req_chan.compare_select;
         s1_in.to_memory      = req_chan.to_memory;
         s1_valid_in          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         state_ff    <= state_in;
      end
   end

   assign rsp_chan.valid        = s2_valid_ff;
   assign rsp_chan.result_value = s2_ff.result_value;
   assign rsp_chan.flags        = s2_ff.flags;
   assign rsp_chan.acc_out      = s2_ff.acc_out;
   assign rsp_chan.x_out        = s2_ff.x_out;
   assign rsp_chan.y_out        = s2_ff.y_out;

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!s1_valid_ff && !s2_valid_ff))
      else $error("pipeline not empty after reset");

   // register state moves only with an ALU transfer
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("register state changed without an ALU transfer");

   // a held request is never dropped
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("pending request lost");

   // narrow index load clears the high byte
   a_ldx_narrow: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_ff.action == ACT_LDX) && !s1_ff.wide)
         |=> (state_ff.x[15:8] == 8'd0))
      else $error("narrow index load left high byte set");

endmodule
`default_nettype wire
